/* rtl/core/tpsa_pkg.sv */
// shared types, constants and helpers for the tensor pad source address block
// no dependencies; used by every module in rtl/core
package tpsa_pkg;

	localparam int unsigned MAX_EXTENT   = 4096;
	localparam int unsigned ADDR_BITS_DEF = 40;

	localparam int unsigned EXT_W   = 13;
	localparam int unsigned COORD_W = 14;
	localparam int unsigned PLANE_W = 16;
	localparam int unsigned FILL_W  = 64;
	localparam int unsigned DATA_W  = 64;
	localparam int unsigned PADDR_W = 6;
	localparam int unsigned RIDX_W  = 3;
	localparam int unsigned R_W     = 17;

	localparam int unsigned EXT_CAP = (MAX_EXTENT < 8191) ? MAX_EXTENT : 8191;

	typedef enum logic [1:0] {
		MODE_CONSTANT = 2'd0,
		MODE_REFLECT  = 2'd1,
		MODE_EDGE     = 2'd2
	} pad_mode_t;

	typedef enum logic [RIDX_W-1:0] {
		REG_PAD_MODE   = 3'd0,
		REG_IN_WIDTH   = 3'd1,
		REG_IN_HEIGHT  = 3'd2,
		REG_IN_DEPTH   = 3'd3,
		REG_PAD_LEFT   = 3'd4,
		REG_PAD_TOP    = 3'd5,
		REG_PAD_FRONT  = 3'd6,
		REG_FILL_VALUE = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic [1:0]       mode;
		logic [EXT_W-1:0] w;
		logic [EXT_W-1:0] h;
		logic [EXT_W-1:0] d;
		logic [EXT_W-1:0] pad_x;
		logic [EXT_W-1:0] pad_y;
		logic [EXT_W-1:0] pad_z;
		logic [FILL_W-1:0] fill;
	} cfg_t;

	function automatic logic [EXT_W-1:0] ext_clamp(input logic [EXT_W-1:0] v);
		logic [EXT_W-1:0] r;
		r = v;
		if (v == '0) begin
			r = EXT_W'(1);
		end else if (v > EXT_W'(EXT_CAP)) begin
			r = EXT_W'(EXT_CAP);
		end
		return r;
	endfunction

endpackage

/* rtl/core/tpsa_regs.sv */
// apb register file holding pad mode, extents, pads and fill word
// depends on tpsa_pkg; extents leave here already clamped
module tpsa_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [tpsa_pkg::PADDR_W-1:0]  paddr,
	input  logic [tpsa_pkg::DATA_W-1:0]   pwdata,
	output logic [tpsa_pkg::DATA_W-1:0]   prdata,
	output logic                          pready,
	output tpsa_pkg::cfg_t                cfg
);

	logic [1:0]                        mode_q;
	logic [tpsa_pkg::EXT_W-1:0]        w_q, h_q, d_q;
	logic [tpsa_pkg::EXT_W-1:0]        px_q, py_q, pz_q;
	logic [tpsa_pkg::FILL_W-1:0]       fill_q;
	tpsa_pkg::reg_idx_t                idx;
	logic                              wr;

	assign pready = 1'b1;
	assign idx    = tpsa_pkg::reg_idx_t'(paddr[tpsa_pkg::PADDR_W-1:3]);
	assign wr     = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= tpsa_pkg::MODE_CONSTANT;
			w_q    <= tpsa_pkg::EXT_W'(1);
			h_q    <= tpsa_pkg::EXT_W'(1);
			d_q    <= tpsa_pkg::EXT_W'(1);
			px_q   <= '0;
			py_q   <= '0;
			pz_q   <= '0;
			fill_q <= '0;
		end else if (wr) begin
			unique case (idx)
				tpsa_pkg::REG_PAD_MODE:   mode_q <= pwdata[1:0];
				tpsa_pkg::REG_IN_WIDTH:   w_q    <= pwdata[tpsa_pkg::EXT_W-1:0];
				tpsa_pkg::REG_IN_HEIGHT:  h_q    <= pwdata[tpsa_pkg::EXT_W-1:0];
				tpsa_pkg::REG_IN_DEPTH:   d_q    <= pwdata[tpsa_pkg::EXT_W-1:0];
				tpsa_pkg::REG_PAD_LEFT:   px_q   <= pwdata[tpsa_pkg::EXT_W-1:0];
				tpsa_pkg::REG_PAD_TOP:    py_q   <= pwdata[tpsa_pkg::EXT_W-1:0];
				tpsa_pkg::REG_PAD_FRONT:  pz_q   <= pwdata[tpsa_pkg::EXT_W-1:0];
				tpsa_pkg::REG_FILL_VALUE: fill_q <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (idx)
			tpsa_pkg::REG_PAD_MODE:   prdata = tpsa_pkg::DATA_W'(mode_q);
			tpsa_pkg::REG_IN_WIDTH:   prdata = tpsa_pkg::DATA_W'(w_q);
			tpsa_pkg::REG_IN_HEIGHT:  prdata = tpsa_pkg::DATA_W'(h_q);
			tpsa_pkg::REG_IN_DEPTH:   prdata = tpsa_pkg::DATA_W'(d_q);
			tpsa_pkg::REG_PAD_LEFT:   prdata = tpsa_pkg::DATA_W'(px_q);
			tpsa_pkg::REG_PAD_TOP:    prdata = tpsa_pkg::DATA_W'(py_q);
			tpsa_pkg::REG_PAD_FRONT:  prdata = tpsa_pkg::DATA_W'(pz_q);
			tpsa_pkg::REG_FILL_VALUE: prdata = fill_q;
			default:                  prdata = '0;
		endcase
	end

	always_comb begin
		cfg.mode  = mode_q;
		cfg.w     = tpsa_pkg::ext_clamp(w_q);
		cfg.h     = tpsa_pkg::ext_clamp(h_q);
		cfg.d     = tpsa_pkg::ext_clamp(d_q);
		cfg.pad_x = px_q;
		cfg.pad_y = py_q;
		cfg.pad_z = pz_q;
		cfg.fill  = fill_q;
	end

endmodule

/* rtl/core/tpsa_axis.sv */
// one axis of the source coordinate map: pad shift, then mirror, clamp or bound test
// depends on tpsa_pkg; instantiated once per axis ahead of stage 1
module tpsa_axis (
	input  logic [1:0]                   mode,
	input  logic [tpsa_pkg::COORD_W-1:0] coord,
	input  logic [tpsa_pkg::EXT_W-1:0]   pad,
	input  logic [tpsa_pkg::EXT_W-1:0]   extent,
	output logic [tpsa_pkg::EXT_W-1:0]   src,
	output logic                         outside
);

	localparam int unsigned RW = tpsa_pkg::R_W;

	logic signed [RW-1:0] r, n, nm1, m;
	logic                 r_neg, r_hi;

	always_comb begin
		n     = $signed(RW'(extent));
		nm1   = n - RW'(1);
		r     = $signed(RW'(coord)) - $signed({{(RW-tpsa_pkg::EXT_W){pad[tpsa_pkg::EXT_W-1]}}, pad});
		r_neg = r < 0;
		r_hi  = r >= n;
		m     = r;
		src     = '0;
		outside = 1'b0;
		unique case (mode)
			tpsa_pkg::MODE_EDGE: begin
				if (r_neg) begin
					src = '0;
				end else if (r_hi) begin
					src = nm1[tpsa_pkg::EXT_W-1:0];
				end else begin
					src = r[tpsa_pkg::EXT_W-1:0];
				end
			end
			tpsa_pkg::MODE_REFLECT: begin
				if (r_neg) begin
					m = -r;
				end else if (r_hi) begin
					m = (nm1 <<< 1) - r;
				end else begin
					m = r;
				end
				if (m < 0) begin
					src     = '0;
					outside = 1'b1;
				end else if (m >= n) begin
					src     = nm1[tpsa_pkg::EXT_W-1:0];
					outside = 1'b1;
				end else begin
					src = m[tpsa_pkg::EXT_W-1:0];
				end
			end
			default: begin
				outside = r_neg | r_hi;
				src     = outside ? '0 : r[tpsa_pkg::EXT_W-1:0];
			end
		endcase
	end

endmodule

/* rtl/core/tpsa_addr.sv */
// flat address pipeline: stages 2 to 4, one multiply-add per stage
// depends on tpsa_pkg; stage 4 registers drive the result ports
module tpsa_addr #(
	parameter int unsigned ADDR_BITS = tpsa_pkg::ADDR_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  tpsa_pkg::cfg_t                cfg,
	input  logic                          vld_s1,
	input  logic [tpsa_pkg::PLANE_W-1:0]  plane_s1,
	input  logic [tpsa_pkg::EXT_W-1:0]    sz_s1,
	input  logic [tpsa_pkg::EXT_W-1:0]    sy_s1,
	input  logic [tpsa_pkg::EXT_W-1:0]    sx_s1,
	input  logic                          fill_s1,
	input  logic                          oor_s1,
	output logic                          done,
	output logic [ADDR_BITS-1:0]          source_address,
	output logic                          use_fill,
	output logic [tpsa_pkg::FILL_W-1:0]   fill_out,
	output logic                          out_of_range
);

	localparam int unsigned EW    = tpsa_pkg::EXT_W;
	localparam int unsigned P1_W  = tpsa_pkg::PLANE_W + EW;
	localparam int unsigned A1_W  = P1_W + 1;
	localparam int unsigned P2_W  = A1_W + EW;
	localparam int unsigned A2_W  = (ADDR_BITS < P2_W) ? ADDR_BITS : P2_W;

	logic                  vld_s2, vld_s3;
	logic [A1_W-1:0]       a1_s2;
	logic [A2_W-1:0]       a2_s3;
	logic [EW-1:0]         sy_s2, sx_s2, sx_s3;
	logic                  fill_s2, fill_s3, oor_s2, oor_s3;
	logic [P1_W-1:0]       prod1;
	logic [P2_W-1:0]       prod2;
	logic [ADDR_BITS-1:0]  prod3;

	assign prod1 = P1_W'(plane_s1) * P1_W'(cfg.d);
	assign prod2 = P2_W'(a1_s2) * P2_W'(cfg.h);
	assign prod3 = ADDR_BITS'(a2_s3) * ADDR_BITS'(cfg.w);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			done   <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			done   <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		a1_s2   <= A1_W'(prod1) + A1_W'(sz_s1);
		sy_s2   <= sy_s1;
		sx_s2   <= sx_s1;
		fill_s2 <= fill_s1;
		oor_s2  <= oor_s1;

		a2_s3   <= A2_W'(prod2 + P2_W'(sy_s2));
		sx_s3   <= sx_s2;
		fill_s3 <= fill_s2;
		oor_s3  <= oor_s2;

		source_address <= fill_s3 ? '0 : prod3 + ADDR_BITS'(sx_s3);
		use_fill       <= fill_s3;
		fill_out       <= fill_s3 ? cfg.fill : '0;
		out_of_range   <= oor_s3 & ~fill_s3;
	end

endmodule

/* rtl/core/tensor_pad_source_address.sv */
// top level of the tensor pad source address generator
// depends on tpsa_pkg, tpsa_regs, tpsa_axis, tpsa_addr
//
//  channel   handshake               payload
//  command   start / busy            plane, out_z, out_y, out_x
//  result    done (one-cycle strobe) source_address, use_fill, fill_out, out_of_range
//  config    apb psel/penable/pready paddr, pwdata, prdata (64-bit, 8-byte stride)
//
// one word accepted every cycle; busy is never raised
// the path is the axis map, then plane*d+z, *h+y and *w+x, one multiply each, each step registered
// the receiver cannot stall, so the pipeline never holds
// reset clears the valid bits and loads the register defaults
module tensor_pad_source_address #(
	parameter int unsigned ADDR_BITS = tpsa_pkg::ADDR_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [tpsa_pkg::PADDR_W-1:0]  paddr,
	input  logic [tpsa_pkg::DATA_W-1:0]   pwdata,
	output logic [tpsa_pkg::DATA_W-1:0]   prdata,
	output logic                          pready,
	input  logic                          start,
	output logic                          busy,
	input  logic [tpsa_pkg::PLANE_W-1:0]  plane,
	input  logic [tpsa_pkg::COORD_W-1:0]  out_z,
	input  logic [tpsa_pkg::COORD_W-1:0]  out_y,
	input  logic [tpsa_pkg::COORD_W-1:0]  out_x,
	output logic                          done,
	output logic [ADDR_BITS-1:0]          source_address,
	output logic                          use_fill,
	output logic [tpsa_pkg::FILL_W-1:0]   fill_out,
	output logic                          out_of_range
);

	tpsa_pkg::cfg_t                 cfg;
	logic [tpsa_pkg::EXT_W-1:0]     sz, sy, sx;
	logic                           oz, oy, ox, outside;
	logic                           is_const, is_refl;
	logic                           vld_s1;
	logic [tpsa_pkg::PLANE_W-1:0]   plane_s1;
	logic [tpsa_pkg::EXT_W-1:0]     sz_s1, sy_s1, sx_s1;
	logic                           fill_s1, oor_s1;

	assign busy = 1'b0;

	tpsa_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	tpsa_axis u_axis_z (
		.mode (cfg.mode), .coord (out_z), .pad (cfg.pad_z), .extent (cfg.d),
		.src (sz), .outside (oz)
	);

	tpsa_axis u_axis_y (
		.mode (cfg.mode), .coord (out_y), .pad (cfg.pad_y), .extent (cfg.h),
		.src (sy), .outside (oy)
	);

	tpsa_axis u_axis_x (
		.mode (cfg.mode), .coord (out_x), .pad (cfg.pad_x), .extent (cfg.w),
		.src (sx), .outside (ox)
	);

	assign outside  = oz | oy | ox;
	assign is_refl  = (cfg.mode == tpsa_pkg::MODE_REFLECT);
	assign is_const = (cfg.mode != tpsa_pkg::MODE_REFLECT) && (cfg.mode != tpsa_pkg::MODE_EDGE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start & ~busy;
		end
	end

	always_ff @(posedge clk) begin
		plane_s1 <= plane;
		sz_s1    <= sz;
		sy_s1    <= sy;
		sx_s1    <= sx;
		fill_s1  <= is_const & outside;
		oor_s1   <= is_refl & outside;
	end

	tpsa_addr #(
		.ADDR_BITS (ADDR_BITS)
	) u_addr (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg),
		.vld_s1         (vld_s1),
		.plane_s1       (plane_s1),
		.sz_s1          (sz_s1),
		.sy_s1          (sy_s1),
		.sx_s1          (sx_s1),
		.fill_s1        (fill_s1),
		.oor_s1         (oor_s1),
		.done           (done),
		.source_address (source_address),
		.use_fill       (use_fill),
		.fill_out       (fill_out),
		.out_of_range   (out_of_range)
	);

endmodule

/* test/tpsa_source_checker.sv */
// checker for tensor_pad_source_address: follows apb register writes, predicts the source
// word for each accepted command word and compares it with the next done strobe
// depends on tpsa_pkg
module tpsa_source_checker
	import tpsa_pkg::*;
#(
	parameter int unsigned ADDR_BITS = ADDR_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [PADDR_W-1:0]   paddr,
	input  logic [DATA_W-1:0]    pwdata,
	input  logic                 pready,
	input  logic                 start,
	input  logic                 busy,
	input  logic [PLANE_W-1:0]   plane,
	input  logic [COORD_W-1:0]   out_z,
	input  logic [COORD_W-1:0]   out_y,
	input  logic [COORD_W-1:0]   out_x,
	input  logic                 done,
	input  logic [ADDR_BITS-1:0] source_address,
	input  logic                 use_fill,
	input  logic [FILL_W-1:0]    fill_out,
	input  logic                 out_of_range,
	output int                   errors,
	output int                   waiting,
	output int                   checked,
	output int                   fills,
	output int                   overshoots
);

	typedef struct {
		logic [ADDR_BITS-1:0] addr;
		logic                 use_fill;
		logic [FILL_W-1:0]    fill;
		logic                 oor;
	} source_t;

	cfg_t    cfg;
	source_t expected_sources[$];
	source_t want;

	function automatic int usable_extent(input logic [EXT_W-1:0] v);
		if (v == '0) begin
			return 1;
		end
		if (int'(v) > int'(MAX_EXTENT)) begin
			return int'(MAX_EXTENT);
		end
		return int'(v);
	endfunction

	function automatic int clamp_into(input int s, input int n);
		if (s < 0) begin
			return 0;
		end
		if (s >= n) begin
			return n - 1;
		end
		return s;
	endfunction

	function automatic int fold_axis(input int coord, input logic [EXT_W-1:0] pad, input int n,
			input logic [1:0] mode, output bit outside);
		int r;
		int s;
		r = coord - int'($signed(pad));
		outside = 1'b0;
		if (mode == MODE_EDGE) begin
			return clamp_into(r, n);
		end
		if (mode == MODE_REFLECT) begin
			if (r < 0) begin
				s = -r;
			end else if (r >= n) begin
				s = 2 * (n - 1) - r;
			end else begin
				s = r;
			end
			if (s < 0 || s >= n) begin
				outside = 1'b1;
				s = clamp_into(s, n);
			end
			return s;
		end
		// constant fill, and the unused mode code
		if (r < 0 || r >= n) begin
			outside = 1'b1;
			return 0;
		end
		return r;
	endfunction

	function automatic source_t map_source(input logic [PLANE_W-1:0] p,
			input logic [COORD_W-1:0] z, input logic [COORD_W-1:0] y,
			input logic [COORD_W-1:0] x);
		int nw, nh, nd;
		int sz, sy, sx;
		bit oz, oy, ox;
		logic [63:0] a;
		source_t e;
		nw = usable_extent(cfg.w);
		nh = usable_extent(cfg.h);
		nd = usable_extent(cfg.d);
		sz = fold_axis(int'(z), cfg.pad_z, nd, cfg.mode, oz);
		sy = fold_axis(int'(y), cfg.pad_y, nh, cfg.mode, oy);
		sx = fold_axis(int'(x), cfg.pad_x, nw, cfg.mode, ox);
		e.addr = '0;
		e.use_fill = 1'b0;
		e.fill = '0;
		e.oor = 1'b0;
		if (cfg.mode != MODE_REFLECT && cfg.mode != MODE_EDGE && (oz || oy || ox)) begin
			e.use_fill = 1'b1;
			e.fill = cfg.fill;
		end else begin
			a = 64'(p) * 64'(nd) + 64'(sz);
			a = a * 64'(nh) + 64'(sy);
			a = a * 64'(nw) + 64'(sx);
			e.addr = a[ADDR_BITS-1:0];
			e.oor = (cfg.mode == MODE_REFLECT) && (oz || oy || ox);
		end
		return e;
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] wanted);
		if (errors < 50) begin
			$display("mismatch on %s: got %h, expected %h", what, got, wanted);
		end
		errors++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg.mode = MODE_CONSTANT;
			cfg.w = EXT_W'(1);
			cfg.h = EXT_W'(1);
			cfg.d = EXT_W'(1);
			cfg.pad_x = '0;
			cfg.pad_y = '0;
			cfg.pad_z = '0;
			cfg.fill = '0;
			expected_sources.delete();
			errors = 0;
			waiting = 0;
			checked = 0;
			fills = 0;
			overshoots = 0;
		end else begin
			if (done) begin
				if (expected_sources.size() == 0) begin
					report_mismatch("result word with nothing waiting", 64'(source_address), '0);
				end else begin
					want = expected_sources.pop_front();
					if (source_address !== want.addr) begin
						report_mismatch("source_address", 64'(source_address), 64'(want.addr));
					end
					if (use_fill !== want.use_fill) begin
						report_mismatch("use_fill", 64'(use_fill), 64'(want.use_fill));
					end
					if (fill_out !== want.fill) begin
						report_mismatch("fill_out", fill_out, want.fill);
					end
					if (out_of_range !== want.oor) begin
						report_mismatch("out_of_range", 64'(out_of_range), 64'(want.oor));
					end
					checked++;
					if (want.use_fill) begin
						fills++;
					end
					if (want.oor) begin
						overshoots++;
					end
				end
			end
			if (start && !busy) begin
				expected_sources = {expected_sources, map_source(plane, out_z, out_y, out_x)};
			end
			if (psel && penable && pwrite && pready) begin
				case (reg_idx_t'(paddr[PADDR_W-1:3]))
					REG_PAD_MODE: cfg.mode = pwdata[1:0];
					REG_IN_WIDTH: cfg.w = pwdata[EXT_W-1:0];
					REG_IN_HEIGHT: cfg.h = pwdata[EXT_W-1:0];
					REG_IN_DEPTH: cfg.d = pwdata[EXT_W-1:0];
					REG_PAD_LEFT: cfg.pad_x = pwdata[EXT_W-1:0];
					REG_PAD_TOP: cfg.pad_y = pwdata[EXT_W-1:0];
					REG_PAD_FRONT: cfg.pad_z = pwdata[EXT_W-1:0];
					REG_FILL_VALUE: cfg.fill = pwdata;
					default: ;
				endcase
			end
			waiting = expected_sources.size();
		end
	end

endmodule

/* test/testbench.sv */
// top of the testbench for tensor_pad_source_address: apb register settings, directed
// and random command words with random gaps, watchdog and verdict
// depends on tpsa_pkg, the rtl core and tpsa_source_checker
module testbench;
	import tpsa_pkg::*;

	localparam logic [1:0] MODE_UNUSED = 2'd3;
	localparam int STALL_LIMIT = 1000;
	localparam int RANDOM_SETTINGS = 12;
	localparam int WORDS_PER_SETTING = 50;
	localparam int COORD_MAX = (1 << COORD_W) - 1;
	localparam int EXT_MAX = (1 << EXT_W) - 1;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       psel = 1'b0;
	logic                       penable = 1'b0;
	logic                       pwrite = 1'b0;
	logic [PADDR_W-1:0]         paddr = '0;
	logic [DATA_W-1:0]          pwdata = '0;
	logic [DATA_W-1:0]          prdata;
	logic                       pready;
	logic                       start = 1'b0;
	logic                       busy;
	logic [PLANE_W-1:0]         plane = '0;
	logic [COORD_W-1:0]         out_z = '0;
	logic [COORD_W-1:0]         out_y = '0;
	logic [COORD_W-1:0]         out_x = '0;
	logic                       done;
	logic [ADDR_BITS_DEF-1:0]   source_address;
	logic                       use_fill;
	logic [FILL_W-1:0]          fill_out;
	logic                       out_of_range;

	int errors, waiting, checked, fills, overshoots;
	int stall_cycles = 0;
	int settings_used = 0;
	bit steady = 1'b0;

	tensor_pad_source_address dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
		.prdata(prdata), .pready(pready),
		.start(start), .busy(busy),
		.plane(plane), .out_z(out_z), .out_y(out_y), .out_x(out_x),
		.done(done), .source_address(source_address), .use_fill(use_fill),
		.fill_out(fill_out), .out_of_range(out_of_range)
	);

	tpsa_source_checker source_check (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
		.pready(pready),
		.start(start), .busy(busy),
		.plane(plane), .out_z(out_z), .out_y(out_y), .out_x(out_x),
		.done(done), .source_address(source_address), .use_fill(use_fill),
		.fill_out(fill_out), .out_of_range(out_of_range),
		.errors(errors), .waiting(waiting), .checked(checked), .fills(fills),
		.overshoots(overshoots)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if ((start && !busy) || done || (psel && penable && pwrite && pready)) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
		if (stall_cycles >= STALL_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// leaves psel high; the caller closes the burst
	task automatic write_reg(input reg_idx_t idx, input logic [DATA_W-1:0] v);
		bit got;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 3'b000};
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		do begin
			@(negedge clk);
			got = pready;
			@(posedge clk);
		end while (!got);
	endtask

	task automatic set_config(input logic [1:0] mode, input logic [EXT_W-1:0] w,
			input logic [EXT_W-1:0] h, input logic [EXT_W-1:0] d, input int px, input int py,
			input int pz, input logic [FILL_W-1:0] fill);
		write_reg(REG_PAD_MODE, 64'(mode));
		write_reg(REG_IN_WIDTH, 64'(w));
		write_reg(REG_IN_HEIGHT, 64'(h));
		write_reg(REG_IN_DEPTH, 64'(d));
		// sign-extended pads, so for a negative pad the bits above the field are ones too
		write_reg(REG_PAD_LEFT, 64'(px));
		write_reg(REG_PAD_TOP, 64'(py));
		write_reg(REG_PAD_FRONT, 64'(pz));
		write_reg(REG_FILL_VALUE, fill);
		psel <= 1'b0;
		penable <= 1'b0;
		settings_used++;
		@(posedge clk);
	endtask

	task automatic issue(input logic [PLANE_W-1:0] p, input logic [COORD_W-1:0] z,
			input logic [COORD_W-1:0] y, input logic [COORD_W-1:0] x);
		bit got;
		while (!steady && $urandom_range(0, 99) < 14) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		plane <= p;
		out_z <= z;
		out_y <= y;
		out_x <= x;
		do begin
			@(negedge clk);
			got = !busy;
			@(posedge clk);
		end while (!got);
	endtask

	task automatic drain();
		start <= 1'b0;
		do begin
			@(negedge clk);
		end while (waiting != 0);
		@(posedge clk);
	endtask

	function automatic logic [EXT_W-1:0] random_extent();
		case ($urandom_range(0, 11))
			0: return '0;
			1: return EXT_W'(MAX_EXTENT);
			2: return EXT_W'($urandom_range(MAX_EXTENT + 1, EXT_MAX));
			default: return EXT_W'($urandom_range(1, 12));
		endcase
	endfunction

	function automatic int random_pad();
		if ($urandom_range(0, 9) == 0) begin
			return int'($signed(EXT_W'($urandom)));
		end
		return int'($urandom_range(0, 40)) - 20;
	endfunction

	// mostly around the input window including both margins, sometimes anywhere
	function automatic logic [COORD_W-1:0] random_coord(input logic [EXT_W-1:0] ext,
			input int pad);
		int n;
		int c;
		if ($urandom_range(0, 99) < 15) begin
			return COORD_W'($urandom);
		end
		n = (ext == '0) ? 1 : int'(ext);
		c = pad - n - 2 + int'($urandom_range(0, 3 * n + 4));
		if (c < 0) begin
			c = 0;
		end
		if (c > COORD_MAX) begin
			c = COORD_MAX;
		end
		return COORD_W'(c);
	endfunction

	initial begin
		int ph, i;
		logic [1:0] mode;
		logic [EXT_W-1:0] w, h, d;
		int px, py, pz;
		logic [PLANE_W-1:0] p;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// register defaults after reset
		issue(16'd0, 14'd0, 14'd0, 14'd0);
		issue(16'hFFFF, 14'd0, 14'd0, 14'd0);
		issue(16'd0, COORD_W'(COORD_MAX), COORD_W'(COORD_MAX), COORD_W'(COORD_MAX));
		drain();

		// constant fill, inside and outside on each axis
		set_config(MODE_CONSTANT, 13'd5, 13'd4, 13'd3, 2, 1, -1, 64'hFFFF_FFFF_FFFF_FFFF);
		issue(16'd7, 14'd1, 14'd1, 14'd2);
		issue(16'd0, 14'd2, 14'd0, 14'd0);
		issue(16'd0, 14'd0, 14'd4, 14'd6);
		issue(16'd0, 14'd2, 14'd5, 14'd6);
		drain();

		// reflect, with overshoot past both ends
		set_config(MODE_REFLECT, 13'd4, 13'd3, 13'd2, 5, 1, 0, 64'h0123_4567_89AB_CDEF);
		issue(16'd1, 14'd0, 14'd0, 14'd0);
		issue(16'd1, 14'd1, 14'd0, 14'd3);
		issue(16'd1, 14'd2, 14'd4, 14'd9);
		issue(16'd2, 14'd3, 14'd5, 14'd12);
		drain();

		// edge replicate at the largest extents and pads, address wraps
		set_config(MODE_EDGE, EXT_W'(MAX_EXTENT), EXT_W'(MAX_EXTENT), EXT_W'(MAX_EXTENT),
			-4095, 4095, -4096, 64'd0);
		issue(16'hFFFF, COORD_W'(COORD_MAX), COORD_W'(COORD_MAX), COORD_W'(COORD_MAX));
		issue(16'hFFFF, 14'd0, 14'd0, 14'd0);
		issue(16'd0, 14'd12286, 14'd4095, 14'd8191);
		drain();

		// unused mode code, zero and oversized extents
		set_config(MODE_UNUSED, EXT_W'(EXT_MAX), EXT_W'(MAX_EXTENT + 1), 13'd0, 0, 0, 1,
			64'hA5A5_5A5A_C3C3_3C3C);
		issue(16'd9, 14'd0, 14'd0, 14'd0);
		issue(16'd9, 14'd1, 14'd4095, 14'd4095);
		issue(16'd9, 14'd1, 14'd0, 14'd4096);
		drain();

		// reflect on a single-element axis
		set_config(MODE_REFLECT, 13'd1, EXT_W'(EXT_MAX), 13'd1, 0, -4095, 0, 64'd1);
		issue(16'd3, 14'd0, 14'd0, 14'd0);
		issue(16'd3, 14'd1, 14'd5000, 14'd1);
		drain();

		for (ph = 0; ph < RANDOM_SETTINGS; ph++) begin
			mode = (ph < 4) ? 2'(ph) : 2'($urandom_range(0, 3));
			w = random_extent();
			h = random_extent();
			d = random_extent();
			px = random_pad();
			py = random_pad();
			pz = random_pad();
			set_config(mode, w, h, d, px, py, pz, {$urandom, $urandom});
			steady = (ph == 5 || ph == 6);
			for (i = 0; i < WORDS_PER_SETTING; i++) begin
				p = ($urandom_range(0, 3) == 0) ? PLANE_W'($urandom_range(0, 3))
					: PLANE_W'($urandom);
				issue(p, random_coord(d, pz), random_coord(h, py), random_coord(w, px));
			end
			drain();
		end

		repeat (8) @(posedge clk);
		$display("%0d register settings, %0d source words checked (%0d fill, %0d reflect overshoot)",
			settings_used, checked, fills, overshoots);
		if (errors == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

/* sim.f */
rtl/core/tpsa_pkg.sv
rtl/core/tpsa_regs.sv
rtl/core/tpsa_axis.sv
rtl/core/tpsa_addr.sv
rtl/core/tensor_pad_source_address.sv
test/tpsa_source_checker.sv
test/testbench.sv
